// ===== rtl/box_mean_blur_macros.svh =====
// Assertion macros shared by the box mean blur RTL.
`ifndef BOX_MEAN_BLUR_MACROS_SVH
`define BOX_MEAN_BLUR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BMB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BMB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmb_pkg.sv =====
// Types, constants and register codes of the box mean blur block.
`timescale 1ns / 1ps

package bmb_pkg;

    // Default store and radius limits
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_RADIUS_DEF = 15;

    // Field widths
    localparam int CH_W       = 8;   // one color channel
    localparam int POS_W      = 6;   // col / row of a word
    localparam int COORD_W    = 7;   // frame size registers and window coordinates
    localparam int RAD_W      = 4;   // radius register
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int PIX_W      = 3 * CH_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [RAD_W-1:0]   RADIUS_RST       = 4'd1;
    localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 7'd64;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 7'd64;

    // Function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_BLUR = 1'b1;

    typedef struct packed {
        logic              func;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [CH_W-1:0]   red_in;
        logic [CH_W-1:0]   green_in;
        logic [CH_W-1:0]   blue_in;
    } t_bmb_in;

    typedef struct packed {
        logic [CH_W-1:0]   red_out;
        logic [CH_W-1:0]   green_out;
        logic [CH_W-1:0]   blue_out;
    } t_bmb_out;

endpackage

// ===== rtl/box_mean_blur.sv =====
// Box mean blur top level: pixel store, window sequencer and shared divider.
// Load word: written to the store at acceptance, no result word.
// Blur word, radius 0: the stored pixel is read in S_BOUND, then passed through S_PASS and S_DONE.
// Blur word with a window: bound, one store read per pixel, drain, then three divider
//   passes, one per channel.
// One word at a time. Sync reset: radius 1, width 64, height 64; store undefined.
`timescale 1ns / 1ps
`include "box_mean_blur_macros.svh"

module box_mean_blur import bmb_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_bmb_in               i_in_word,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_bmb_out              o_out_word,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int FULL_W   = ADDR_W + COORD_W + 1;
    localparam int SPAN_MAX = 2 * MAX_RADIUS;
    localparam int CNT_W    = $clog2(SPAN_MAX * SPAN_MAX + 1);
    localparam int SUM_W    = $clog2(SPAN_MAX * SPAN_MAX * ((1 << CH_W) - 1) + 1);
    localparam int DIV_W    = CNT_W + CH_W;
    localparam int B_W      = COORD_W + 2;

    // channel being divided
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUND,
        S_PASS,
        S_SCAN,
        S_DRAIN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [RAD_W-1:0]    r_radius;
    logic [COORD_W-1:0]  r_frame_width;
    logic [COORD_W-1:0]  r_frame_height;
    logic [COORD_W-1:0]  r_rs;
    logic [COORD_W-1:0]  r_cs;
    logic [COORD_W-1:0]  r_r0;
    logic [COORD_W-1:0]  r_r1;
    logic [COORD_W-1:0]  r_c0;
    logic [COORD_W-1:0]  r_c1;
    logic                r_rd_pend;
    logic [SUM_W-1:0]    r_sum_red;
    logic [SUM_W-1:0]    r_sum_green;
    logic [SUM_W-1:0]    r_sum_blue;
    logic [CNT_W-1:0]    r_count;
    logic [1:0]          r_chan;
    logic [CH_W-1:0]     r_q_red;
    logic [CH_W-1:0]     r_q_green;
    logic [CH_W-1:0]     r_q_blue;
    logic                r_out_vld;
    t_bmb_out            r_out;
    logic [PIX_W-1:0]    r_mem_q;
    logic [PIX_W-1:0]    r_mem [DEPTH];

    logic                    w_in_acc;
    logic                    w_load_go;
    logic                    w_in_store;
    logic [RAD_W-1:0]        w_rad;
    logic [COORD_W-1:0]      w_w;
    logic [COORD_W-1:0]      w_h;
    logic signed [B_W-1:0]   w_row_s;
    logic signed [B_W-1:0]   w_col_s;
    logic signed [B_W-1:0]   w_rad_s;
    logic signed [B_W-1:0]   w_lo_r;
    logic signed [B_W-1:0]   w_lo_c;
    logic signed [B_W-1:0]   w_hi_r;
    logic signed [B_W-1:0]   w_hi_c;
    logic signed [B_W-1:0]   w_lim_r;
    logic signed [B_W-1:0]   w_lim_c;
    logic signed [B_W-1:0]   w_r0;
    logic signed [B_W-1:0]   w_r1;
    logic signed [B_W-1:0]   w_c0;
    logic signed [B_W-1:0]   w_c1;
    logic                    w_empty;
    logic [COORD_W-1:0]      w_rs_nx;
    logic [COORD_W-1:0]      w_cs_nx;
    logic [2*COORD_W-1:0]    w_area;
    logic [FULL_W-1:0]       w_scan_full;
    logic [FULL_W-1:0]       w_load_full;
    logic [ADDR_W-1:0]       w_mem_addr;
    logic [PIX_W-1:0]        w_load_pix;
    logic                    w_div_start;
    logic [SUM_W-1:0]        w_div_sum;
    logic                    w_div_done;
    logic [CH_W-1:0]         w_div_quot;

    // handshakes; no word is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // clamp registers to the store limits
    assign w_rad = (int'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_radius;
    assign w_w   = (int'(r_frame_width) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : r_frame_width;
    assign w_h   = (int'(r_frame_height) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : r_frame_height;

    // window bounds around the captured position (r_rs, r_cs)
    assign w_row_s = $signed(B_W'(r_rs));
    assign w_col_s = $signed(B_W'(r_cs));
    assign w_rad_s = $signed(B_W'(w_rad));
    assign w_lim_r = $signed(B_W'(w_h)) - $signed(B_W'(1));
    assign w_lim_c = $signed(B_W'(w_w)) - $signed(B_W'(1));
    assign w_lo_r  = w_row_s - w_rad_s;
    assign w_lo_c  = w_col_s - w_rad_s;
    assign w_hi_r  = w_row_s + w_rad_s;
    assign w_hi_c  = w_col_s + w_rad_s;
    assign w_r0    = (w_lo_r < $signed(B_W'(0))) ? $signed(B_W'(0)) : w_lo_r;
    assign w_c0    = (w_lo_c < $signed(B_W'(0))) ? $signed(B_W'(0)) : w_lo_c;
    assign w_r1    = (w_hi_r < w_lim_r) ? w_hi_r : w_lim_r;
    assign w_c1    = (w_hi_c < w_lim_c) ? w_hi_c : w_lim_c;
    assign w_empty = (w_r1 <= w_r0) || (w_c1 <= w_c0);

    assign w_in_store = (int'(r_cs) < MAX_WIDTH) && (int'(r_rs) < MAX_HEIGHT);

    // raster walk over the window
    assign w_rs_nx = r_rs + 1'b1;
    assign w_cs_nx = r_cs + 1'b1;
    assign w_area  = (r_r1 - r_r0) * (r_c1 - r_c0);

    // store addressing: row * MAX_WIDTH + col
    assign w_scan_full = FULL_W'(r_rs) * FULL_W'(MAX_WIDTH) + FULL_W'(r_cs);
    assign w_load_full = FULL_W'(i_in_word.row) * FULL_W'(MAX_WIDTH) + FULL_W'(i_in_word.col);
    assign w_load_go   = w_in_acc && (i_in_word.func == FUNC_LOAD)
                         && (int'(i_in_word.col) < MAX_WIDTH)
                         && (int'(i_in_word.row) < MAX_HEIGHT);
    assign w_mem_addr  = w_load_go ? w_load_full[ADDR_W-1:0] : w_scan_full[ADDR_W-1:0];
    assign w_load_pix  = {i_in_word.red_in, i_in_word.green_in, i_in_word.blue_in};

    // pixel store, single port, registered read
    always_ff @(posedge i_clk) begin
        if (w_load_go) begin
            r_mem[w_mem_addr] <= w_load_pix;
        end
        r_mem_q <= r_mem[w_mem_addr];
    end

    // divider operand select
    always_comb begin
        case (r_chan)
            CH_RED:   w_div_sum = r_sum_red;
            CH_GREEN: w_div_sum = r_sum_green;
            CH_BLUE:  w_div_sum = r_sum_blue;
            default:  w_div_sum = r_sum_red;
        endcase
    end

    assign w_div_start = (r_state == S_DIV_GO);

    bmb_divider #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (DIV_W'(w_div_sum)),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // sequencer, registers and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_radius       <= RADIUS_RST;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_rd_pend      <= 1'b0;
            r_out_vld      <= 1'b0;
            r_chan         <= CH_RED;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:       r_radius       <= i_cfg_data[RAD_W-1:0];
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[COORD_W-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end

            // result taken; in S_DONE the register is refilled instead
            if (r_out_vld && i_out_ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end

            // accumulate read data, which arrives in the cycle after its address
            r_rd_pend <= (r_state == S_SCAN);
            if (r_rd_pend) begin
                r_sum_red   <= r_sum_red   + SUM_W'(r_mem_q[3*CH_W-1:2*CH_W]);
                r_sum_green <= r_sum_green + SUM_W'(r_mem_q[2*CH_W-1:CH_W]);
                r_sum_blue  <= r_sum_blue  + SUM_W'(r_mem_q[CH_W-1:0]);
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in_word.func == FUNC_BLUR)) begin
                        r_rs    <= COORD_W'(i_in_word.row);
                        r_cs    <= COORD_W'(i_in_word.col);
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    if (w_rad == '0) begin
                        // pass-through: the store is read at (row, col) this cycle
                        if (w_in_store) begin
                            r_state <= S_PASS;
                        end else begin
                            r_q_red   <= '0;
                            r_q_green <= '0;
                            r_q_blue  <= '0;
                            r_state   <= S_DONE;
                        end
                    end else if (w_empty) begin
                        r_q_red   <= '0;
                        r_q_green <= '0;
                        r_q_blue  <= '0;
                        r_state   <= S_DONE;
                    end else begin
                        r_r0        <= w_r0[COORD_W-1:0];
                        r_r1        <= w_r1[COORD_W-1:0];
                        r_c0        <= w_c0[COORD_W-1:0];
                        r_c1        <= w_c1[COORD_W-1:0];
                        r_rs        <= w_r0[COORD_W-1:0];
                        r_cs        <= w_c0[COORD_W-1:0];
                        r_sum_red   <= '0;
                        r_sum_green <= '0;
                        r_sum_blue  <= '0;
                        r_state     <= S_SCAN;
                    end
                end
                S_PASS: begin
                    r_q_red   <= r_mem_q[3*CH_W-1:2*CH_W];
                    r_q_green <= r_mem_q[2*CH_W-1:CH_W];
                    r_q_blue  <= r_mem_q[CH_W-1:0];
                    r_state   <= S_DONE;
                end
                S_SCAN: begin
                    r_count <= CNT_W'(w_area);
                    if (w_cs_nx == r_c1) begin
                        r_cs <= r_c0;
                        if (w_rs_nx == r_r1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_rs <= w_rs_nx;
                        end
                    end else begin
                        r_cs <= w_cs_nx;
                    end
                end
                S_DRAIN: begin
                    r_chan  <= CH_RED;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        case (r_chan)
                            CH_RED:   r_q_red   <= w_div_quot;
                            CH_GREEN: r_q_green <= w_div_quot;
                            CH_BLUE:  r_q_blue  <= w_div_quot;
                            default: ;
                        endcase
                        if (r_chan == CH_BLUE) begin
                            r_state <= S_DONE;
                        end else begin
                            r_chan  <= r_chan + 1'b1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_DONE: begin
                    // hand over once the result register is free
                    if (!r_out_vld || i_out_ready) begin
                        r_out.red_out   <= r_q_red;
                        r_out.green_out <= r_q_green;
                        r_out.blue_out  <= r_q_blue;
                        r_out_vld       <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `BMB_ASSERT_NOW(a_scan_in_window, r_state == S_SCAN,
        (r_rs >= r_r0) && (r_rs < r_r1) && (r_cs >= r_c0) && (r_cs < r_c1),
        "window walk left its bounds")
    `BMB_ASSERT_NOW(a_sum_settled, r_state == S_DIV_GO, !r_rd_pend,
        "division started before the last pixel was summed")
    `BMB_ASSERT_NOW(a_count_nonzero, r_state == S_DIV_WAIT, r_count != '0,
        "division by an empty window")
    `BMB_ASSERT_NEXT(a_div_advance, (r_state == S_DIV_WAIT) && w_div_done,
        (r_state == S_DIV_GO) || (r_state == S_DONE),
        "divider result not consumed")

endmodule

// ===== rtl/bmb_divider.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit one channel.
`timescale 1ns / 1ps

module bmb_divider import bmb_pkg::*; #(
    parameter int CNT_W = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CNT_W+CH_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]      i_divisor,
    output logic                  o_done,
    output logic [CH_W-1:0]       o_quot
);

    localparam int DIV_W  = CNT_W + CH_W;
    localparam int STEP_W = $clog2(CH_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_trial;
    logic [CH_W-1:0]   r_quot;
    logic              w_ge;

    // trial subtrahend is divisor shifted to the current quotient bit
    assign w_ge = (r_rem >= r_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem   <= i_dividend;
                r_trial <= DIV_W'(i_divisor) << (CH_W - 1);
                r_step  <= STEP_W'(CH_W - 1);
                r_quot  <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_trial;
                end
                r_quot  <= {r_quot[CH_W-2:0], w_ge};
                r_trial <= r_trial >> 1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== verif/box_mean_blur_tb.sv =====
// Self-checking testbench for the box mean blur block: directed table, then random phases.
`timescale 1ns / 1ps

module box_mean_blur_tb;
    import bmb_pkg::*;

    localparam int N_WORDS       = 1850;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 1000;
    localparam int STORE_DEPTH   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {STEP_WORD, STEP_REG} t_step_kind;

    typedef struct {
        t_step_kind             kind;
        t_bmb_in                word;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        bit                     has_known;
        t_bmb_out               known;
    } t_plan_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_bmb_in               i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_bmb_out              o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow of the block: pixel store, written map and registers
    logic [PIX_W-1:0]   frame_mem [0:STORE_DEPTH-1];
    bit                 loaded    [0:STORE_DEPTH-1];
    logic [RAD_W-1:0]   radius_q;
    logic [COORD_W-1:0] width_q;
    logic [COORD_W-1:0] height_q;

    t_bmb_out   blur_q[$];
    t_plan_step plan[$];

    bit calm;
    int fail_count;
    int words_sent;
    int loads_sent;
    int blurs_sent;
    int settings_used;
    int widest_window;
    int cycle_count;

    box_mean_blur dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 30);
    endfunction

    // Window bounds under the current registers; empty when r1 <= r0 or c1 <= c0
    function automatic void blur_span(input int col, input int row,
                                      output int c0, output int c1,
                                      output int r0, output int r1);
        int rad, w, h;
        rad = (radius_q > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_q;
        w   = (width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_q;
        h   = (height_q > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_q;
        r0  = (row - rad < 0) ? 0 : row - rad;
        r1  = (row + rad < h - 1) ? row + rad : h - 1;
        c0  = (col - rad < 0) ? 0 : col - rad;
        c1  = (col + rad < w - 1) ? col + rad : w - 1;
    endfunction

    // Truncated per-channel mean over the window, or the stored pixel at radius zero
    function automatic t_bmb_out blur_expect(input int col, input int row);
        t_bmb_out         res;
        logic [PIX_W-1:0] px;
        int               c0, c1, r0, r1;
        int               sr, sg, sb, n;
        res = '0;
        if (radius_q == 0) begin
            res = frame_mem[row * MAX_WIDTH_DEF + col];
        end else begin
            blur_span(col, row, c0, c1, r0, r1);
            if (r1 > r0 && c1 > c0) begin
                sr = 0;
                sg = 0;
                sb = 0;
                for (int r = r0; r < r1; r++) begin
                    for (int c = c0; c < c1; c++) begin
                        px = frame_mem[r * MAX_WIDTH_DEF + c];
                        sr += px[23:16];
                        sg += px[15:8];
                        sb += px[7:0];
                    end
                end
                n = (r1 - r0) * (c1 - c0);
                if (n > widest_window) widest_window = n;
                res.red_out   = CH_W'(sr / n);
                res.green_out = CH_W'(sg / n);
                res.blue_out  = CH_W'(sb / n);
            end
        end
        return res;
    endfunction

    function automatic t_bmb_in make_word(input logic func, input int col, input int row);
        t_bmb_in w;
        w.func     = func;
        w.col      = POS_W'(col);
        w.row      = POS_W'(row);
        w.red_in   = CH_W'($urandom_range(0, 255));
        w.green_in = CH_W'($urandom_range(0, 255));
        w.blue_in  = CH_W'($urandom_range(0, 255));
        return w;
    endfunction

    // Mostly inside the frame, sometimes anywhere in the store
    function automatic int pick_pos(input int size);
        int lim;
        lim = (size > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : size;
        if (lim > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, lim - 1);
        return $urandom_range(0, MAX_WIDTH_DEF - 1);
    endfunction

    function automatic int extreme_size();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return MAX_WIDTH_DEF;
            4:       return MAX_WIDTH_DEF + 1;
            default: return 127;
        endcase
    endfunction

    function automatic t_plan_step plan_load(input int col, input int row,
                                             input logic [PIX_W-1:0] pix);
        t_plan_step s;
        s = '{kind: STEP_WORD, default: '0};
        s.word = {FUNC_LOAD, POS_W'(col), POS_W'(row), pix};
        return s;
    endfunction

    function automatic t_plan_step plan_blur(input int col, input int row,
                                             input bit has_known, input t_bmb_out known);
        t_plan_step s;
        s = '{kind: STEP_WORD, default: '0};
        s.word      = make_word(FUNC_BLUR, col, row);
        s.has_known = has_known;
        s.known     = known;
        return s;
    endfunction

    function automatic t_plan_step plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        t_plan_step s;
        s = '{kind: STEP_REG, default: '0};
        s.reg_idx  = idx;
        s.reg_data = data;
        return s;
    endfunction

    // Offer one word, then update the shadow at the accepting edge
    task automatic send_word(input t_bmb_in w, input bit use_known, input t_bmb_out known);
        while (idle_roll()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        words_sent++;
        if (w.func == FUNC_LOAD) begin
            frame_mem[{w.row, w.col}] = {w.red_in, w.green_in, w.blue_in};
            loaded[{w.row, w.col}]    = 1'b1;
            loads_sent++;
        end else begin
            blur_q.push_back(use_known ? known : blur_expect(w.col, w.row));
            blurs_sent++;
        end
    endtask

    // Load every pixel a blur at (col,row) would read that has not been written yet
    task automatic fill_window(input int col, input int row);
        int c0, c1, r0, r1;
        if (radius_q == 0) begin
            c0 = col;
            c1 = col + 1;
            r0 = row;
            r1 = row + 1;
        end else begin
            blur_span(col, row, c0, c1, r0, r1);
        end
        for (int r = r0; r < r1; r++) begin
            for (int c = c0; c < c1; c++) begin
                if (!loaded[r * MAX_WIDTH_DEF + c])
                    send_word(make_word(FUNC_LOAD, c, r), 1'b0, '0);
            end
        end
    endtask

    // Register write once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RADIUS:       radius_q = data[RAD_W-1:0];
            CFG_FRAME_WIDTH:  width_q  = data;
            CFG_FRAME_HEIGHT: height_q = data;
            default:          ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result side: random back-pressure and compare against the oldest expectation
    initial begin
        t_bmb_out want;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (blur_q.size() == 0) begin
                    $display("%0t: result word %h with nothing expected", $time, o_out_word);
                    fail_count++;
                end else begin
                    want = blur_q.pop_front();
                    check_field("red_out", want.red_out, o_out_word.red_out);
                    check_field("green_out", want.green_out, o_out_word.green_out);
                    check_field("blue_out", want.blue_out, o_out_word.blue_out);
                end
            end
            i_out_ready <= !idle_roll();
        end
    end

    // Stimulus
    initial begin
        int kind, rad, wid, hgt, n_items, col, row, phase;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        calm          = 1'b0;
        fail_count    = 0;
        words_sent    = 0;
        loads_sent    = 0;
        blurs_sent    = 0;
        settings_used = 1;
        widest_window = 0;
        radius_q = RADIUS_RST;
        width_q  = FRAME_WIDTH_RST;
        height_q = FRAME_HEIGHT_RST;
        foreach (loaded[i]) loaded[i] = 1'b0;

        // Directed table: reset registers, clamping, pass-through and empty windows
        plan.push_back(plan_load(0, 0, 24'hFF0180));
        plan.push_back(plan_blur(0, 0, 1'b1, 24'hFF0180));
        plan.push_back(plan_load(1, 0, 24'hFF0000));
        plan.push_back(plan_load(0, 1, 24'hFF0000));
        plan.push_back(plan_load(1, 1, 24'hFF0300));
        plan.push_back(plan_blur(1, 1, 1'b1, 24'hFF0120));
        plan.push_back(plan_load(63, 63, 24'h123456));
        plan.push_back(plan_load(62, 62, 24'hAABBCC));
        plan.push_back(plan_reg(CFG_FRAME_WIDTH, 7'd127));
        plan.push_back(plan_reg(CFG_FRAME_HEIGHT, 7'd127));
        plan.push_back(plan_blur(63, 63, 1'b1, 24'hAABBCC));
        plan.push_back(plan_reg(CFG_RADIUS, 7'd0));
        plan.push_back(plan_blur(63, 63, 1'b1, 24'h123456));
        plan.push_back(plan_reg(CFG_FRAME_WIDTH, 7'd2));
        plan.push_back(plan_blur(63, 63, 1'b1, 24'h123456));
        plan.push_back(plan_reg(CFG_RADIUS, 7'd1));
        plan.push_back(plan_blur(63, 63, 1'b1, 24'h000000));
        plan.push_back(plan_reg(CFG_FRAME_HEIGHT, 7'd1));
        plan.push_back(plan_blur(0, 0, 1'b1, 24'h000000));
        plan.push_back(plan_reg(CFG_FRAME_HEIGHT, 7'd64));
        plan.push_back(plan_reg(CFG_FRAME_WIDTH, 7'd0));
        plan.push_back(plan_blur(0, 0, 1'b1, 24'h000000));
        plan.push_back(plan_reg(CFG_SPARE, 7'h7F));
        plan.push_back(plan_reg(CFG_FRAME_WIDTH, 7'd3));
        plan.push_back(plan_blur(1, 1, 1'b0, '0));
        plan.push_back(plan_blur(2, 1, 1'b0, '0));
        plan.push_back(plan_load(1, 1, 24'h000000));
        plan.push_back(plan_blur(2, 1, 1'b0, '0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                write_reg(plan[i].reg_idx, plan[i].reg_data);
                settings_used++;
            end else begin
                send_word(plan[i].word, plan[i].has_known, plan[i].known);
            end
        end

        // Random phases: new registers, then a mix of loads and blurs
        phase = 0;
        while (words_sent < N_WORDS) begin
            calm = (phase >= 6 && phase < 10);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                rad     = $urandom_range(0, 1) ? MAX_RADIUS_DEF : 0;
                wid     = extreme_size();
                hgt     = extreme_size();
                n_items = 4;
            end else begin
                rad     = (kind < 8) ? $urandom_range(0, 3) : $urandom_range(4, MAX_RADIUS_DEF);
                wid     = (kind == 7) ? $urandom_range(25, 127) : $urandom_range(2, 20);
                hgt     = (kind == 7) ? $urandom_range(25, 127) : $urandom_range(2, 20);
                n_items = $urandom_range(20, 50);
            end
            write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
            write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wid));
            write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(hgt));
            settings_used++;

            repeat (n_items) begin
                if (words_sent >= N_WORDS) break;
                col = pick_pos(wid);
                row = pick_pos(hgt);
                if ($urandom_range(0, 99) < 25) begin
                    send_word(make_word(FUNC_LOAD, col, row), 1'b0, '0);
                end else begin
                    fill_window(col, row);
                    send_word(make_word(FUNC_BLUR, col, row), 1'b0, '0);
                end
            end
            phase++;
        end
        calm = 1'b0;

        // Drain
        i_in_valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: sent %0d words (%0d loads, %0d blurs) over %0d register settings",
                 words_sent, loads_sent, blurs_sent, settings_used);
        $display("tb: widest window %0d pixels, %0d mismatches", widest_window, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
